@@ rtl/core/rrc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rrc_pkg;

   // fixed field widths
   localparam int unsigned RATIO_W    = 32;
   localparam int unsigned GAIN_W     = 24;
   localparam int unsigned THR_W      = 15;
   localparam int unsigned CHCOUNT_W  = 2;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 32;

   // shared multiplier operand width, fits gain and any sample magnitude
   localparam int unsigned MUL_W = 24;

   // ratio is Q8.24, gain is Q8.16, so the product is shifted by the difference
   localparam int unsigned FRAC_SHIFT = 8;

   localparam logic [RATIO_W-1:0] RATIO_ONE = 32'h0100_0000;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_COUNT   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD_LEVEL = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PEAK_RATIO      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ATTACK_STEP     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE_STEP    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MAKEUP_GAIN     = 3'd5;

   // register reset values
   localparam logic [CHCOUNT_W-1:0] CHANNEL_COUNT_RST   = 2'd1;
   localparam logic [THR_W-1:0]     THRESHOLD_LEVEL_RST = 15'd10361;
   localparam logic [RATIO_W-1:0]   PEAK_RATIO_RST      = 32'd67108864;
   localparam logic [RATIO_W-1:0]   ATTACK_STEP_RST     = 32'd3804;
   localparam logic [RATIO_W-1:0]   RELEASE_STEP_RST    = 32'd1427;
   localparam logic [GAIN_W-1:0]    MAKEUP_GAIN_RST     = 24'd65536;

   typedef struct packed {
      logic [CHCOUNT_W-1:0] channel_count;
      logic [THR_W-1:0]     threshold_level;
      logic [RATIO_W-1:0]   peak_ratio;
      logic [RATIO_W-1:0]   attack_step;
      logic [RATIO_W-1:0]   release_step;
      logic [GAIN_W-1:0]    makeup_gain;
   } cfg_type;

   // datapath operations issued by the controller
   typedef enum logic [3:0] {
      OP_NONE,
      OP_CLEAR,
      OP_LOAD,
      OP_SQ_NEW,
      OP_SQ_OLD,
      OP_SQ_THR,
      OP_CMP,
      OP_RATIO,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_OUT
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic div_last;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

@@ rtl/core/rrc_csr.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rrc_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [rrc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [rrc_pkg::CSR_DATA_W-1:0]   csr_data,
   output rrc_pkg::cfg_type                      cfg
);
   import rrc_pkg::*;

   cfg_type cfg_ff;

   // writes are always taken
   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // register file, each write keeps the low bits of the data
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.channel_count   <= CHANNEL_COUNT_RST;
         cfg_ff.threshold_level <= THRESHOLD_LEVEL_RST;
         cfg_ff.peak_ratio      <= PEAK_RATIO_RST;
         cfg_ff.attack_step     <= ATTACK_STEP_RST;
         cfg_ff.release_step    <= RELEASE_STEP_RST;
         cfg_ff.makeup_gain     <= MAKEUP_GAIN_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_CHANNEL_COUNT:   cfg_ff.channel_count   <= csr_data[CHCOUNT_W-1:0];
            CSR_THRESHOLD_LEVEL: cfg_ff.threshold_level <= csr_data[THR_W-1:0];
            CSR_PEAK_RATIO:      cfg_ff.peak_ratio      <= csr_data[RATIO_W-1:0];
            CSR_ATTACK_STEP:     cfg_ff.attack_step     <= csr_data[RATIO_W-1:0];
            CSR_RELEASE_STEP:    cfg_ff.release_step    <= csr_data[RATIO_W-1:0];
            CSR_MAKEUP_GAIN:     cfg_ff.makeup_gain     <= csr_data[GAIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/rrc_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rrc_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  rrc_pkg::status_type      status,
   output rrc_pkg::cmd_type         cmd
);
   import rrc_pkg::*;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_SQ_NEW,
      S_SQ_OLD,
      S_SQ_THR,
      S_CMP,
      S_RATIO,
      S_DIV_INIT,
      S_DIV,
      S_OUT
   } state_type;

   state_type state_ff;

   assign req_ready = (state_ff == S_IDLE);

   // state sequence: clear pass after reset, then one item at a time
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         unique case (state_ff)
            S_CLEAR: begin
               if (status.clear_last) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (req_valid) state_ff <= S_SQ_NEW;
            end
            S_SQ_NEW:   state_ff <= S_SQ_OLD;
            S_SQ_OLD:   state_ff <= S_SQ_THR;
            S_SQ_THR:   state_ff <= S_CMP;
            S_CMP:      state_ff <= S_RATIO;
            S_RATIO:    state_ff <= S_DIV_INIT;
            S_DIV_INIT: state_ff <= S_DIV;
            S_DIV: begin
               if (status.div_last) state_ff <= S_OUT;
            end
            S_OUT: begin
               if (status.out_free) state_ff <= S_IDLE;
            end
            default: state_ff <= S_CLEAR;
         endcase
      end
   end

   // operation for the datapath in each state
   always_comb begin
      cmd.op = OP_NONE;
      unique case (state_ff)
         S_CLEAR:    cmd.op = OP_CLEAR;
         S_IDLE:     cmd.op = req_valid ? OP_LOAD : OP_NONE;
         S_SQ_NEW:   cmd.op = OP_SQ_NEW;
         S_SQ_OLD:   cmd.op = OP_SQ_OLD;
         S_SQ_THR:   cmd.op = OP_SQ_THR;
         S_CMP:      cmd.op = OP_CMP;
         S_RATIO:    cmd.op = OP_RATIO;
         S_DIV_INIT: cmd.op = OP_DIV_INIT;
         S_DIV:      cmd.op = OP_DIV_STEP;
         S_OUT:      cmd.op = status.out_free ? OP_OUT : OP_NONE;
         default:    cmd.op = OP_NONE;
      endcase
   end

endmodule

`default_nettype wire

@@ rtl/core/rrc_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rrc_datapath #(
   parameter int unsigned WINDOW_LEN   = 512,
   parameter int unsigned SAMPLE_BITS  = 16,
   parameter int unsigned MAX_CHANNELS = 2
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  rrc_pkg::cmd_type                   cmd,
   input  rrc_pkg::cfg_type                   cfg,
   output rrc_pkg::status_type                status,
   input  wire logic signed [SAMPLE_BITS-1:0] req_sample,
   input  wire logic                          req_channel,
   input  wire logic                          rsp_ready,
   output logic                               rsp_valid,
   output logic signed [SAMPLE_BITS-1:0]      rsp_out_sample,
   output logic                               rsp_compressing
);
   import rrc_pkg::*;

   localparam int unsigned SB     = SAMPLE_BITS;
   localparam int unsigned POS_W  = $clog2(WINDOW_LEN);
   localparam int unsigned CH_AW  = $clog2(MAX_CHANNELS);
   localparam int unsigned AW     = POS_W + CH_AW;
   localparam int unsigned DEPTH  = 1 << AW;
   localparam int unsigned EW     = 2 * SB - 1 + POS_W;
   localparam int unsigned ACC_W  = EW + 1;
   localparam int unsigned CW     = (EW > 2 * THR_W) ? EW : 2 * THR_W;
   localparam int unsigned PROD_W = 2 * MUL_W;
   localparam int unsigned NUM_W  = SB + MUL_W + FRAC_SHIFT;
   localparam int unsigned DIV_W  = RATIO_W + SB - 2;
   localparam int unsigned CNT_W  = $clog2(SAMPLE_BITS);
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW_LEN - 1);

   // window memory
   logic [SB-1:0]      mem [DEPTH];
   logic [AW-1:0]      mem_addr;
   logic               mem_we;
   logic [SB-1:0]      mem_wdata;
   logic [SB-1:0]      old_ff;

   // control state
   logic [POS_W-1:0]   pos_ff;
   logic [AW-1:0]      clr_ff;
   logic [RATIO_W-1:0] ratio_ff;
   logic [EW-1:0]      energy_ff [MAX_CHANNELS];
   logic               rsp_valid_ff;

   // payload registers
   logic [SB-1:0]      sample_ff;
   logic [SB-1:0]      mag_ff;
   logic               neg_ff;
   logic               ch_ff;
   logic [AW-1:0]      addr_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic [ACC_W-1:0]   acc_ff;
   logic               above_ff;
   logic [NUM_W-1:0]   rem_ff;
   logic [DIV_W-1:0]   dsh_ff;
   logic [SB-2:0]      q_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic               ovf_ff;
   logic [SB-1:0]      rsp_sample_ff;
   logic               rsp_comp_ff;

   // combinational helpers
   logic [SB-1:0]      in_bits;
   logic [SB-1:0]      in_mag;
   logic [SB-1:0]      old_mag;
   logic               ch_in;
   logic [1:0]         nch_eff;
   logic               advance;
   logic [MUL_W-1:0]   mul_a;
   logic [MUL_W-1:0]   mul_b;
   logic [PROD_W-1:0]  mul_p;
   logic [EW-1:0]      energy_cur;
   logic [RATIO_W-1:0] peak_eff;
   logic [RATIO_W:0]   ratio_up;
   logic [RATIO_W:0]   rel_floor;
   logic               div_ge;
   logic [SB-1:0]      q_ext;
   logic [SB-1:0]      sat_val;
   logic [SB-1:0]      res;

   // input magnitude and channel clamping
   assign in_bits = req_sample;
   assign in_mag  = in_bits[SB-1] ? ((~in_bits) + SB'(1)) : in_bits;
   assign old_mag = old_ff[SB-1] ? ((~old_ff) + SB'(1)) : old_ff;
   assign ch_in   = (MAX_CHANNELS < 2) ? 1'b0 : req_channel;

   always_comb begin
      if (cfg.channel_count == 2'd0) begin
         nch_eff = 2'd1;
      end else if (cfg.channel_count > 2'(MAX_CHANNELS)) begin
         nch_eff = 2'(MAX_CHANNELS);
      end else begin
         nch_eff = cfg.channel_count;
      end
   end

   // last channel of the frame moves the ring position
   assign advance = ({1'b0, ch_in} == (nch_eff - 2'd1));

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.op)
         OP_SQ_NEW: begin
            mul_a = MUL_W'(mag_ff);
            mul_b = MUL_W'(mag_ff);
         end
         OP_SQ_OLD: begin
            mul_a = MUL_W'(old_mag);
            mul_b = MUL_W'(old_mag);
         end
         OP_SQ_THR: begin
            mul_a = MUL_W'(cfg.threshold_level);
            mul_b = MUL_W'(cfg.threshold_level);
         end
         OP_CMP: begin
            mul_a = MUL_W'(mag_ff);
            mul_b = cfg.makeup_gain;
         end
         default: begin
         end
      endcase
   end

   assign mul_p      = PROD_W'(mul_a) * PROD_W'(mul_b);
   assign energy_cur = energy_ff[ch_ff];

   // ratio ramp limits
   assign peak_eff  = (cfg.peak_ratio < RATIO_ONE) ? RATIO_ONE : cfg.peak_ratio;
   assign ratio_up  = {1'b0, ratio_ff} + {1'b0, cfg.attack_step};
   assign rel_floor = {1'b0, RATIO_ONE} + {1'b0, cfg.release_step};

   // divider step compare
   assign div_ge = (rem_ff >= NUM_W'(dsh_ff));

   // sign restore and saturation
   assign q_ext   = {1'b0, q_ff};
   assign sat_val = neg_ff ? {1'b1, {(SB - 1){1'b0}}} : {1'b0, {(SB - 1){1'b1}}};
   assign res     = ovf_ff ? sat_val : (neg_ff ? ((~q_ext) + SB'(1)) : q_ext);

   // memory port: clear sweep or read-old/write-new of one entry
   always_comb begin
      mem_addr  = (cmd.op == OP_CLEAR) ? clr_ff : addr_ff;
      mem_we    = (cmd.op == OP_CLEAR) || (cmd.op == OP_SQ_NEW);
      mem_wdata = (cmd.op == OP_CLEAR) ? '0 : sample_ff;
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_addr] <= mem_wdata;
      if (cmd.op == OP_SQ_NEW) old_ff <= mem[mem_addr];
   end

   // control state: position, clear counter, ratio, energies, result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         clr_ff       <= '0;
         ratio_ff     <= RATIO_ONE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_CHANNELS; i++) energy_ff[i] <= '0;
      end else begin
         if (cmd.op == OP_CLEAR) clr_ff <= clr_ff + AW'(1);
         if (cmd.op == OP_LOAD && advance) begin
            pos_ff <= (pos_ff == POS_LAST) ? '0 : pos_ff + POS_W'(1);
         end
         if (cmd.op == OP_SQ_THR) begin
            energy_ff[ch_ff] <= EW'(acc_ff - ACC_W'(prod_ff));
         end
         if (cmd.op == OP_RATIO) begin
            if (above_ff) begin
               ratio_ff <= (ratio_up > {1'b0, peak_eff}) ? peak_eff : ratio_up[RATIO_W-1:0];
            end else begin
               ratio_ff <= ({1'b0, ratio_ff} < rel_floor) ? RATIO_ONE
                                                          : ratio_ff - cfg.release_step;
            end
         end
         if (cmd.op == OP_OUT) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload: item capture, squares, compare, restoring divide, output
   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_LOAD: begin
            sample_ff <= in_bits;
            mag_ff    <= in_mag;
            neg_ff    <= in_bits[SB-1];
            ch_ff     <= ch_in;
            addr_ff   <= AW'({ch_in, pos_ff});
         end
         OP_SQ_NEW: begin
            prod_ff <= mul_p;
         end
         OP_SQ_OLD: begin
            acc_ff  <= ACC_W'(energy_cur) + ACC_W'(prod_ff);
            prod_ff <= mul_p;
         end
         OP_SQ_THR: begin
            prod_ff <= mul_p;
         end
         OP_CMP: begin
            above_ff <= (CW'(energy_cur) > CW'(prod_ff));
            prod_ff  <= mul_p;
         end
         OP_RATIO: begin
            rem_ff <= {prod_ff[SB+MUL_W-1:0], {FRAC_SHIFT{1'b0}}};
         end
         OP_DIV_INIT: begin
            ovf_ff <= (rem_ff >= (NUM_W'(ratio_ff) << (SB - 1)));
            dsh_ff <= DIV_W'(ratio_ff) << (SB - 2);
            q_ff   <= '0;
            cnt_ff <= CNT_W'(SB - 1);
         end
         OP_DIV_STEP: begin
            if (div_ge) rem_ff <= rem_ff - NUM_W'(dsh_ff);
            q_ff   <= {q_ff[SB-3:0], div_ge};
            dsh_ff <= dsh_ff >> 1;
            cnt_ff <= cnt_ff - CNT_W'(1);
         end
         OP_OUT: begin
            rsp_sample_ff <= res;
            rsp_comp_ff   <= above_ff;
         end
         default: begin
         end
      endcase
   end

   assign status.clear_last = (clr_ff == {AW{1'b1}});
   assign status.div_last   = (cnt_ff == CNT_W'(1));
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_sample  = rsp_sample_ff;
   assign rsp_compressing = rsp_comp_ff;

endmodule

`default_nettype wire

@@ rtl/core/rms_ratio_ramp_compressor.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Windowed-RMS audio compressor with a ramped ratio. Each item is one signed
// sample tagged with its channel (up to two, interleaved). Per channel a ring
// of the last WINDOW_LEN samples and its sum of squares is kept; when that sum
// exceeds threshold_level squared the shared Q8.24 ratio ramps up by
// attack_step (capped at peak_ratio), otherwise down by release_step (floored
// at 1.0). The result is makeup_gain * sample / ratio, truncated toward zero
// and saturated. After an item is accepted the block runs the squares, the
// compare, the ratio update and the restoring divider, which yields one
// quotient bit per cycle, before rsp_valid rises. Items are worked on one at
// a time: no new item is accepted until the last one's result has gone to the
// output register. A finished result waits in that output register while the
// next item is taken, and the next result holds the block until the waiting
// one is taken. After reset the whole window memory is cleared, during which
// no item is accepted; configuration writes are taken at any time and must
// only be issued while the block is idle.

module rms_ratio_ramp_compressor #(
   parameter int unsigned WINDOW_LEN   = 512,
   parameter int unsigned SAMPLE_BITS  = 16,
   parameter int unsigned MAX_CHANNELS = 2
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic signed [SAMPLE_BITS-1:0]    req_sample,
   input  wire logic                             req_channel,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]         rsp_out_sample,
   output logic                                  rsp_compressing,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [rrc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [rrc_pkg::CSR_DATA_W-1:0]   csr_data
);
   import rrc_pkg::*;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   // configuration registers
   rrc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // sequencer
   rrc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // window memory, energies, ratio, multiplier and divider
   rrc_datapath #(
      .WINDOW_LEN   (WINDOW_LEN),
      .SAMPLE_BITS  (SAMPLE_BITS),
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .cfg             (cfg),
      .status          (status),
      .req_sample      (req_sample),
      .req_channel     (req_channel),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_out_sample  (rsp_out_sample),
      .rsp_compressing (rsp_compressing)
   );

endmodule

`default_nettype wire

@@ rtl/core/rrc_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rrc_checker #(
   parameter int unsigned SAMPLE_BITS = 16
) (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_valid,
   input wire logic                   req_ready,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_ready,
   input wire logic [SAMPLE_BITS-1:0] rsp_out_sample,
   input wire logic                   rsp_compressing
);

   // a stalled result holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_sample)
                                  && $stable(rsp_compressing))
      else $error("result changed while stalled");

   // reset starts the clear sweep with no result pending
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("block not quiet after reset");

   // one item at a time: an accepted item closes the input
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input open while an item is in work");

   // a new result only comes out of a busy block
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result appeared without an item in work");

endmodule

bind rms_ratio_ramp_compressor rrc_checker #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_rrc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_out_sample  (rsp_out_sample),
   .rsp_compressing (rsp_compressing)
);

`default_nettype wire
